@@ hw/rtl/gsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the geometry string parser
// Item layouts, parser state record, token kinds, corner codes and limits.
// ----------------------------------------------------------------------------
package gsp_pkg;

   // Character codes that open a token
   localparam logic [7:0] CHAR_SIZE  = 8'h78;   // 'x'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;   // '-'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;   // '9'

   // Token limit and largest accepted value
   localparam logic [2:0]  MAX_TOKENS = 3'd4;
   localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;
   localparam logic [31:0] UNSET      = 32'hFFFF_FFFF;

   // Token kinds
   localparam logic [1:0] KIND_SIZE  = 2'd0;
   localparam logic [1:0] KIND_PLUS  = 2'd1;
   localparam logic [1:0] KIND_MINUS = 2'd2;

   // Corner codes
   localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
   localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd1;
   localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd2;
   localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd3;

   // Input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } item_type;

   // Result item
   typedef struct packed {
      logic signed [31:0] height_value;
      logic signed [31:0] width_value;
      logic signed [31:0] y_offset;
      logic signed [31:0] x_offset;
      logic [1:0]         corner;
   } result_type;

   // Parser state
   typedef struct packed {
      logic [2:0]  token_count;
      logic        in_token;
      logic        digit_seen;
      logic [1:0]  token_kind;
      logic [30:0] accumulator;
      logic        acc_overflow;
      logic        stopped;
      logic [31:0] width_reg;
      logic [31:0] height_reg;
      logic [31:0] xoff_reg;
      logic [31:0] yoff_reg;
      logic [1:0]  corner_reg;
   } state_type;

   localparam state_type STATE_RESET = '{
      token_count:  3'd0,
      in_token:     1'b0,
      digit_seen:   1'b0,
      token_kind:   KIND_SIZE,
      accumulator:  31'd0,
      acc_overflow: 1'b0,
      stopped:      1'b0,
      width_reg:    UNSET,
      height_reg:   UNSET,
      xoff_reg:     UNSET,
      yoff_reg:     UNSET,
      corner_reg:   CORNER_TOP_LEFT
   };

endpackage : gsp_pkg
`default_nettype wire

@@ hw/rtl/gsp_in_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_in_reg: input item register
// Holds one input item until the parser takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module gsp_in_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,      // item accepted on the input side
   input  gsp_pkg::item_type     item,
   input  wire                   advance,   // parser takes the held item
   output logic                  valid,
   output gsp_pkg::item_type     held
);

   logic              vld_ff, vld_in;
   gsp_pkg::item_type item_ff;

   // Track occupancy
   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign valid = vld_ff;
   assign held  = item_ff;

endmodule : gsp_in_reg
`default_nettype wire

@@ hw/rtl/gsp_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_parser_core: per-byte geometry token scanner
// Updates parser state from one item per cycle on advance, forms the result.
// ----------------------------------------------------------------------------
module gsp_parser_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  gsp_pkg::item_type     item,
   output gsp_pkg::result_type   result
);

   gsp_pkg::state_type state_ff, state_in;
   gsp_pkg::state_type fin;

   // Append one decimal digit, saturating on overflow
   function automatic gsp_pkg::state_type add_digit(gsp_pkg::state_type s,
                                                    logic [3:0] d);
      logic [34:0] nxt;
      nxt = ({4'd0, s.accumulator} << 3) + ({4'd0, s.accumulator} << 1)
            + {31'd0, d};
      s.digit_seen = 1'b1;
      if (s.acc_overflow || (nxt > {4'd0, gsp_pkg::VALUE_MAX})) begin
         s.acc_overflow = 1'b1;
         s.accumulator  = gsp_pkg::VALUE_MAX;
      end else begin
         s.accumulator = nxt[30:0];
      end
      return s;
   endfunction

   // Complete the pending token: apply its value or stop on a fault
   function automatic gsp_pkg::state_type finish_token(gsp_pkg::state_type s);
      logic [31:0] val;
      val = {1'b0, s.accumulator};
      s.in_token = 1'b0;
      if (!s.digit_seen || s.acc_overflow) begin
         s.stopped = 1'b1;
      end else begin
         if (s.token_kind == gsp_pkg::KIND_SIZE) begin
            if (!s.width_reg[31]) begin
               s.height_reg = val;
            end else begin
               s.width_reg = val;
            end
         end else if (!s.xoff_reg[31]) begin
            s.yoff_reg = val;
            if (s.token_kind == gsp_pkg::KIND_MINUS) begin
               s.corner_reg = (s.corner_reg == gsp_pkg::CORNER_TOP_RIGHT) ?
                              gsp_pkg::CORNER_BOTTOM_RIGHT :
                              gsp_pkg::CORNER_BOTTOM_LEFT;
            end
         end else begin
            s.xoff_reg = val;
            if (s.token_kind == gsp_pkg::KIND_MINUS) begin
               s.corner_reg = gsp_pkg::CORNER_TOP_RIGHT;
            end
         end
         s.token_count = s.token_count + 3'd1;
         if (s.token_count >= gsp_pkg::MAX_TOKENS) begin
            s.stopped = 1'b1;
         end
      end
      return s;
   endfunction

   // Open a token on an operator or a leading digit
   function automatic gsp_pkg::state_type start_token(gsp_pkg::state_type s,
                                                      logic [7:0] c);
      logic is_digit;
      is_digit = (c >= gsp_pkg::CHAR_ZERO) && (c <= gsp_pkg::CHAR_NINE);
      if (s.token_count >= gsp_pkg::MAX_TOKENS) begin
         s.stopped = 1'b1;
      end else begin
         s.in_token     = 1'b1;
         s.digit_seen   = 1'b0;
         s.accumulator  = 31'd0;
         s.acc_overflow = 1'b0;
         if (c == gsp_pkg::CHAR_SIZE) begin
            s.token_kind = gsp_pkg::KIND_SIZE;
         end else if (c == gsp_pkg::CHAR_PLUS) begin
            s.token_kind = gsp_pkg::KIND_PLUS;
         end else if (c == gsp_pkg::CHAR_MINUS) begin
            s.token_kind = gsp_pkg::KIND_MINUS;
         end else if (is_digit) begin
            s.token_kind = gsp_pkg::KIND_SIZE;
            s = add_digit(s, 4'(c - gsp_pkg::CHAR_ZERO));
         end else begin
            s.in_token = 1'b0;
            s.stopped  = 1'b1;
         end
      end
      return s;
   endfunction

   // Next state for the item under work
   always_comb begin
      fin      = state_ff;
      state_in = state_ff;
      if (item.end_of_string) begin
         if (!state_ff.stopped && state_ff.in_token) begin
            fin = finish_token(state_ff);
         end
         state_in = gsp_pkg::STATE_RESET;
      end else if (!state_ff.stopped) begin
         if (state_ff.in_token && (item.char_code >= gsp_pkg::CHAR_ZERO) &&
             (item.char_code <= gsp_pkg::CHAR_NINE)) begin
            state_in = add_digit(state_ff, 4'(item.char_code - gsp_pkg::CHAR_ZERO));
         end else begin
            if (state_ff.in_token) begin
               state_in = finish_token(state_ff);
            end
            if (!state_in.stopped) begin
               state_in = start_token(state_in, item.char_code);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsp_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result fields from the completed state
   assign result.corner       = fin.corner_reg;
   assign result.x_offset     = fin.xoff_reg;
   assign result.y_offset     = fin.yoff_reg;
   assign result.width_value  = fin.width_reg;
   assign result.height_value = fin.height_reg;

endmodule : gsp_parser_core
`default_nettype wire

@@ hw/rtl/gsp_out_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_out_reg: result item register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module gsp_out_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load,
   input  gsp_pkg::result_type   result,
   input  wire                   take,     // consumer ready
   output logic                  free,     // register can take a result now
   output logic                  valid,
   output gsp_pkg::result_type   held
);

   logic                vld_ff, vld_in;
   gsp_pkg::result_type res_ff;

   assign free = !vld_ff || take;

   // Track occupancy
   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign valid = vld_ff;
   assign held  = res_ff;

endmodule : gsp_out_reg
`default_nettype wire

@@ hw/rtl/geometry_spec_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// geometry_spec_parser: streaming parser for window geometry strings
// Takes one byte per item, emits width, height, offsets and corner at the end.
//
//   channel  direction  payload                                  last
//   req_     in         tdata[7:0] char_code                     end_of_string
//   rsp_     out        tdata corner, x, y, width, height         -
//
// One item per cycle unless stalled; a byte reaches the parser in the cycle
// after acceptance and a result shows on rsp_ in the cycle after its end item
// is parsed. The per-byte update (multiply by ten, compare) sets the rate.
// Synchronous reset clears both item registers and the parser state.
// A stalled result holds back the next end item and the input behind it;
// bytes ahead of that end item keep flowing meanwhile.
// ----------------------------------------------------------------------------
module geometry_spec_parser (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_tvalid,
   output logic          req_tready,
   input  wire  [7:0]    req_tdata,    // [7:0] char_code
   input  wire           req_tlast,    // end_of_string
   output logic          rsp_tvalid,
   input  wire           rsp_tready,
   output logic [135:0]  rsp_tdata     // [1:0] corner, [33:2] x_offset,
                                       // [65:34] y_offset, [97:66] width_value,
                                       // [129:98] height_value, [135:130] zero
);

   gsp_pkg::item_type   req_item;
   gsp_pkg::item_type   held_item;
   gsp_pkg::result_type core_result;
   gsp_pkg::result_type rsp_result;
   logic                in_valid;
   logic                out_free;
   logic                advance;
   logic                req_accept;

   assign req_item.char_code     = req_tdata;
   assign req_item.end_of_string = req_tlast;

   // Advance unless an end item waits for a full result register
   assign advance    = in_valid && (!held_item.end_of_string || out_free);
   assign req_tready = !in_valid || advance;
   assign req_accept = req_tvalid && req_tready;

   gsp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (req_accept),
      .item    (req_item),
      .advance (advance),
      .valid   (in_valid),
      .held    (held_item)
   );

   gsp_parser_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .result  (core_result)
   );

   gsp_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && held_item.end_of_string),
      .result  (core_result),
      .take    (rsp_tready),
      .free    (out_free),
      .valid   (rsp_tvalid),
      .held    (rsp_result)
   );

   // Pack the result, first field lowest
   assign rsp_tdata = {6'd0, rsp_result.height_value, rsp_result.width_value,
                       rsp_result.y_offset, rsp_result.x_offset, rsp_result.corner};

endmodule : geometry_spec_parser
`default_nettype wire

@@ hw/rtl/gsp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_checker: port-level checks of the geometry string parser
// Watches the result channel for stall behavior and consistent geometry.
// ----------------------------------------------------------------------------
module gsp_checker (
   input wire          clock,
   input wire          reset,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire [135:0]  rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed or dropped");

   // Drop any result after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Right-hand corner needs an x offset
   a_right_needs_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[33])
      else $error("right corner without x offset");

   // Bottom corner and y offset need an x offset before them
   a_bottom_needs_y: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1] || !rsp_tdata[65]) |-> !rsp_tdata[65] && !rsp_tdata[33])
      else $error("bottom corner or y offset without offsets");

   // Height is only set after width
   a_height_needs_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[129] |-> !rsp_tdata[97])
      else $error("height set without width");

endmodule : gsp_checker

bind geometry_spec_parser gsp_checker u_gsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ tb/geometry_spec_parser_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// geometry_spec_parser_tb: self-checking bench for the geometry string parser
// Streams geometry strings one byte per item, predicts each end-of-string
// result in a behavioral parser model, and compares every result field by
// field. A short directed sweep comes first, then well-formed random strings
// mixed with noise, under three idle patterns on both channels.
// ----------------------------------------------------------------------------
module geometry_spec_parser_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1300;

   // DUT-facing signals
   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic [7:0]    req_tdata  = 8'h00;   // [7:0] char_code
   logic          req_tlast  = 1'b0;    // end_of_string
   logic          rsp_tready = 1'b0;
   wire           req_tready;
   wire           rsp_tvalid;
   wire  [135:0]  rsp_tdata;            // [1:0] corner, [33:2] x_offset,
                                        // [65:34] y_offset, [97:66] width_value,
                                        // [129:98] height_value, [135:130] zero

   // Hand-written expectation travelling alongside the item being driven
   logic                note_typed = 1'b0;
   gsp_pkg::result_type note_value = '0;

   typedef struct {
      logic [7:0]          char_code;
      logic                last;
      logic                typed;
      gsp_pkg::result_type want;
   } directed_row_type;

   directed_row_type    directed_rows[$];
   gsp_pkg::result_type expected_geometry[$];
   gsp_pkg::state_type  geom_st = gsp_pkg::STATE_RESET;
   int                  sender_idle_pct   = 21;
   int                  receiver_idle_pct = 66;
   int                  random_items_sent = 0;
   int                  error_count       = 0;
   int                  cycle_count       = 0;

   geometry_spec_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("geometry_spec_parser: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- parser model

   function automatic bit is_digit(input logic [7:0] c);
      return (c >= gsp_pkg::CHAR_ZERO) && (c <= gsp_pkg::CHAR_NINE);
   endfunction

   // Fold one decimal digit into the value, saturating on overflow
   function automatic void push_digit(input logic [3:0] d);
      longint unsigned next_val;
      next_val = longint'(geom_st.accumulator) * 10 + d;
      geom_st.digit_seen = 1'b1;
      if (geom_st.acc_overflow || next_val > gsp_pkg::VALUE_MAX) begin
         geom_st.acc_overflow = 1'b1;
         geom_st.accumulator  = gsp_pkg::VALUE_MAX;
      end else begin
         geom_st.accumulator = next_val[30:0];
      end
   endfunction

   // Apply the pending token, or stop on an empty or overflowed run
   function automatic void close_token();
      geom_st.in_token = 1'b0;
      if (!geom_st.digit_seen || geom_st.acc_overflow) begin
         geom_st.stopped = 1'b1;
         return;
      end
      if (geom_st.token_kind == gsp_pkg::KIND_SIZE) begin
         if (!geom_st.width_reg[31])
            geom_st.height_reg = {1'b0, geom_st.accumulator};
         else
            geom_st.width_reg = {1'b0, geom_st.accumulator};
      end else if (!geom_st.xoff_reg[31]) begin
         geom_st.yoff_reg = {1'b0, geom_st.accumulator};
         if (geom_st.token_kind == gsp_pkg::KIND_MINUS)
            geom_st.corner_reg = (geom_st.corner_reg == gsp_pkg::CORNER_TOP_RIGHT) ?
                                 gsp_pkg::CORNER_BOTTOM_RIGHT :
                                 gsp_pkg::CORNER_BOTTOM_LEFT;
      end else begin
         geom_st.xoff_reg = {1'b0, geom_st.accumulator};
         if (geom_st.token_kind == gsp_pkg::KIND_MINUS)
            geom_st.corner_reg = gsp_pkg::CORNER_TOP_RIGHT;
      end
      geom_st.token_count = geom_st.token_count + 3'd1;
      if (geom_st.token_count >= gsp_pkg::MAX_TOKENS)
         geom_st.stopped = 1'b1;
   endfunction

   // Begin a token on an operator or a digit; anything else stops parsing
   function automatic void open_token(input logic [7:0] c);
      if (geom_st.token_count >= gsp_pkg::MAX_TOKENS) begin
         geom_st.stopped = 1'b1;
         return;
      end
      geom_st.in_token     = 1'b1;
      geom_st.digit_seen   = 1'b0;
      geom_st.accumulator  = '0;
      geom_st.acc_overflow = 1'b0;
      if (c == gsp_pkg::CHAR_SIZE) begin
         geom_st.token_kind = gsp_pkg::KIND_SIZE;
      end else if (c == gsp_pkg::CHAR_PLUS) begin
         geom_st.token_kind = gsp_pkg::KIND_PLUS;
      end else if (c == gsp_pkg::CHAR_MINUS) begin
         geom_st.token_kind = gsp_pkg::KIND_MINUS;
      end else if (is_digit(c)) begin
         geom_st.token_kind = gsp_pkg::KIND_SIZE;
         push_digit(4'(c - gsp_pkg::CHAR_ZERO));
      end else begin
         geom_st.in_token = 1'b0;
         geom_st.stopped  = 1'b1;
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      if (geom_st.stopped)
         return;
      if (geom_st.in_token) begin
         if (is_digit(c)) begin
            push_digit(4'(c - gsp_pkg::CHAR_ZERO));
            return;
         end
         close_token();
         if (geom_st.stopped)
            return;
      end
      open_token(c);
   endfunction

   // Complete the string, report what was gathered and clear the model
   function automatic gsp_pkg::result_type finish_geometry();
      gsp_pkg::result_type r;
      if (!geom_st.stopped && geom_st.in_token)
         close_token();
      r.corner       = geom_st.corner_reg;
      r.x_offset     = geom_st.xoff_reg;
      r.y_offset     = geom_st.yoff_reg;
      r.width_value  = geom_st.width_reg;
      r.height_value = geom_st.height_reg;
      geom_st = gsp_pkg::STATE_RESET;
      return r;
   endfunction

   function automatic gsp_pkg::result_type make_geometry(input logic [1:0] corner,
                                                         input logic [31:0] x, y, w, h);
      gsp_pkg::result_type r;
      r.corner       = corner;
      r.x_offset     = x;
      r.y_offset     = y;
      r.width_value  = w;
      r.height_value = h;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] want_v, got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s expected %0d got %0d", $time, name,
                  $signed(want_v), $signed(got_v));
      end
   endtask

   // Track accepted items on both channels
   always @(posedge clock) begin : watch_items
      gsp_pkg::result_type want;
      gsp_pkg::result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tlast) begin
               want = finish_geometry();
               if (note_typed)
                  want = note_value;
               expected_geometry.push_back(want);
            end else begin
               parse_byte(req_tdata);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = gsp_pkg::result_type'(rsp_tdata[129:0]);
            if (expected_geometry.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected: %h", $time, rsp_tdata);
            end else begin
               want = expected_geometry.pop_front();
               check_field("corner", {30'd0, want.corner}, {30'd0, got.corner});
               check_field("x_offset", want.x_offset, got.x_offset);
               check_field("y_offset", want.y_offset, got.y_offset);
               check_field("width_value", want.width_value, got.width_value);
               check_field("height_value", want.height_value, got.height_value);
               check_field("pad", 32'd0, {26'd0, rsp_tdata[135:130]});
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Drive one item after a random gap and hold it until accepted
   task automatic send_item(input logic [7:0] c, input logic last,
                            input logic typed, input gsp_pkg::result_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      note_typed <= typed;
      note_value <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_item(c, 1'b0, 1'b0, '0);
      random_items_sent++;
   endtask

   // One random geometry string: mostly tokens with digit runs, some noise
   task automatic send_random_geometry();
      int                ntok;
      int                pick;
      int                zeros;
      longint unsigned   v;
      string             digits;
      ntok = $urandom_range(0, 5);
      for (int k = 0; k < ntok; k++) begin
         if ($urandom_range(11) == 0) begin
            send_byte(8'($urandom_range(255)));
            continue;
         end
         pick = $urandom_range(3);
         if (pick == 0)
            send_byte(gsp_pkg::CHAR_SIZE);
         else if (pick == 1)
            send_byte(gsp_pkg::CHAR_PLUS);
         else if (pick == 2)
            send_byte(gsp_pkg::CHAR_MINUS);
         // occasionally leave an operator without digits
         if (pick != 3 && $urandom_range(15) == 0)
            continue;
         pick = $urandom_range(9);
         if (pick <= 5)
            v = $urandom_range(999);
         else if (pick == 6)
            v = $urandom & 32'h7FFF_FFFF;
         else if (pick == 7)
            v = longint'(gsp_pkg::VALUE_MAX) - 4 + $urandom_range(8);
         else if (pick == 8)
            v = {$urandom, $urandom} % 64'd1_000_000_000_000;
         else
            v = $urandom_range(99);
         digits = $sformatf("%0d", v);
         if (pick == 9) begin
            zeros = $urandom_range(1, 3);
            repeat (zeros) digits = {"0", digits};
         end
         for (int i = 0; i < digits.len(); i++)
            send_byte(digits[i]);
      end
      send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      random_items_sent++;
   endtask

   function automatic void add_row(input logic [7:0] c, input logic last,
                                   input logic typed, input gsp_pkg::result_type want);
      directed_row_type row;
      row.char_code = c;
      row.last      = last;
      row.typed     = typed;
      row.want      = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_row(s[i], 1'b0, 1'b0, '0);
   endfunction

   initial begin
      // empty string
      add_row(8'h00, 1'b1, 1'b1,
              make_geometry(gsp_pkg::CORNER_TOP_LEFT, gsp_pkg::UNSET, gsp_pkg::UNSET,
                            gsp_pkg::UNSET, gsp_pkg::UNSET));
      // bad character with every bit set, then the end item
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b1,
              make_geometry(gsp_pkg::CORNER_TOP_LEFT, gsp_pkg::UNSET, gsp_pkg::UNSET,
                            gsp_pkg::UNSET, gsp_pkg::UNSET));
      // operator with an empty digit run
      add_text("+");
      add_row(8'h5A, 1'b1, 1'b1,
              make_geometry(gsp_pkg::CORNER_TOP_LEFT, gsp_pkg::UNSET, gsp_pkg::UNSET,
                            gsp_pkg::UNSET, gsp_pkg::UNSET));
      // largest value, both minus corners, fourth token stops the rest
      add_text("2147483647x0-1-2+");
      add_row(8'hA5, 1'b1, 1'b1,
              make_geometry(gsp_pkg::CORNER_BOTTOM_RIGHT, 32'd1, 32'd2,
                            {1'b0, gsp_pkg::VALUE_MAX}, 32'd0));
      // plus offset kept, overflowing size dropped
      add_text("+7x2147483648");
      add_row(8'h00, 1'b1, 1'b1,
              make_geometry(gsp_pkg::CORNER_TOP_LEFT, 32'd7, gsp_pkg::UNSET,
                            gsp_pkg::UNSET, gsp_pkg::UNSET));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed sweep
      foreach (directed_rows[i])
         send_item(directed_rows[i].char_code, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);

      // random strings under three idle patterns
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 21 : (phase == 1) ? 66 : 0;
         receiver_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 21 : 0;
         while (random_items_sent < (phase + 1) * RANDOM_ITEMS / 3)
            send_random_geometry();
      end
      req_tvalid <= 1'b0;

      // drain outstanding results
      @(posedge clock);
      wait (expected_geometry.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("geometry_spec_parser: match");
      else
         $display("geometry_spec_parser: mismatch");
      $finish;
   end

endmodule : geometry_spec_parser_tb
`default_nettype wire

@@ geometry_spec_parser.f @@
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_in_reg.sv
hw/rtl/gsp_parser_core.sv
hw/rtl/gsp_out_reg.sv
hw/rtl/geometry_spec_parser.sv
hw/rtl/gsp_checker.sv
tb/geometry_spec_parser_tb.sv
